FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and helpers for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int CODE_W = 10;
    localparam int PRIO_W = 5;
    localparam int ENT_W  = CODE_W + PRIO_W;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic [ENT_W-1:0] entry_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
        logic              last;
    } result_t;

    // (idx + off) modulo DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, idx} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic result_t make_result(input logic [ST_W-1:0]  status,
                                            input entry_t           ent,
                                            input logic             has_ent,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic             last);
        result_t r;
        r.status = status;
        r.code   = has_ent ? ent[ENT_W-1:PRIO_W] : '0;
        r.prio   = has_ent ? ent[PRIO_W-1:0] : '0;
        r.occ    = OCC_W'(cnt);
        r.last   = last;
        return r;
    endfunction

endpackage

FILE: hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Priority queue with first-in, first-out order among equal priorities.
// ----------------------------------------------------------------------------
// Entries live in a single RAM used as a circular buffer from a head pointer,
// sorted by ascending priority. One transaction is taken at a time. An insert
// moves each stored entry of higher priority up a slot, one entry per cycle,
// since the shift goes through the one read and one write port of the RAM. A
// dump gives one result per stored entry. Results leave through an output
// register; a stalled output holds the sequencer. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [spq_pkg::OP_W-1:0]    s_opcode,
    input  logic [spq_pkg::CODE_W-1:0]  s_item_code,
    input  logic [spq_pkg::PRIO_W-1:0]  s_item_priority,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [spq_pkg::ST_W-1:0]    m_status,
    output logic [spq_pkg::CODE_W-1:0]  m_out_code,
    output logic [spq_pkg::PRIO_W-1:0]  m_out_priority,
    output logic [spq_pkg::OCC_W-1:0]   m_occupancy,
    output logic                        m_last
);
    import spq_pkg::*;

    logic             res_valid;
    result_t          res;
    logic             res_take;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;

    spq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .op        (s_opcode),
        .code      (s_item_code),
        .prio      (s_item_priority),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    spq_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (ENT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output slot is free when empty or being drained this cycle
    assign res_take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_take) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_out_code     = out_reg.code;
    assign m_out_priority = out_reg.prio;
    assign m_occupancy    = out_reg.occ;
    assign m_last         = out_reg.last;

endmodule

FILE: hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 15
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer: keeps head pointer and count of a circular store in RAM,
// shifts entries one per cycle on insert, walks the store on dump.
// ----------------------------------------------------------------------------
module spq_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [spq_pkg::OP_W-1:0]  op,
    input  logic [spq_pkg::CODE_W-1:0] code,
    input  logic [spq_pkg::PRIO_W-1:0] prio,
    output logic                      res_valid,
    output spq_pkg::result_t          res,
    input  logic                      res_take,
    output logic                      wr_en,
    output logic [spq_pkg::IDX_W-1:0] wr_addr,
    output spq_pkg::entry_t           wr_data,
    output logic                      rd_en,
    output logic [spq_pkg::IDX_W-1:0] rd_addr,
    input  spq_pkg::entry_t           rd_data
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_HEAD = 3'd2;
    localparam logic [2:0] S_REM      = 3'd3;
    localparam logic [2:0] S_DUMP     = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] j_reg, j_next;
    entry_t           new_reg, new_next;
    result_t          pend_reg, pend_next;

    logic             dump_last;
    logic [IDX_W-1:0] j_inc;
    logic [IDX_W-1:0] j_dec;
    logic [IDX_W-1:0] cnt_m1;

    assign j_inc     = j_reg + IDX_W'(1);
    assign j_dec     = j_reg - IDX_W'(1);
    assign cnt_m1    = IDX_W'(count_reg - CNT_W'(1));
    assign dump_last = (CNT_W'(j_reg) + CNT_W'(1)) == count_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) || (state_reg == S_DUMP);
    assign res       = (state_reg == S_DUMP)
                     ? make_result(ST_OK, rd_data, 1'b1, count_reg, dump_last)
                     : pend_reg;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        j_next     = j_reg;
        new_next   = new_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (op)
                        OP_INSERT: begin
                            new_next = {code, prio};
                            if (count_reg == CNT_W'(DEPTH)) begin
                                pend_next  = make_result(ST_FULL, '0, 1'b0,
                                                         count_reg, 1'b1);
                                state_next = S_EMIT;
                            end else if (count_reg == '0) begin
                                wr_en      = 1'b1;
                                wr_addr    = head_reg;
                                wr_data    = {code, prio};
                                count_next = count_reg + CNT_W'(1);
                                pend_next  = make_result(ST_OK, '0, 1'b0,
                                                         count_next, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = wrap_add(head_reg, cnt_m1);
                                j_next     = cnt_m1;
                                state_next = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (count_reg == '0) begin
                                pend_next  = make_result(ST_EMPTY, '0, 1'b0,
                                                         count_reg, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_REM;
                            end
                        end
                        OP_DUMP: begin
                            if (count_reg == '0) begin
                                pend_next  = make_result(ST_EMPTY, '0, 1'b0,
                                                         count_reg, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                j_next     = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            pend_next  = make_result(ST_OK, '0, 1'b0,
                                                     count_reg, 1'b1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, j_inc);
                if (rd_data[PRIO_W-1:0] > new_reg[PRIO_W-1:0]) begin
                    wr_data = rd_data;
                    if (j_reg == '0) begin
                        state_next = S_INS_HEAD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = wrap_add(head_reg, j_dec);
                        j_next  = j_dec;
                    end
                end else begin
                    wr_data    = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    pend_next  = make_result(ST_OK, '0, 1'b0, count_next, 1'b1);
                    state_next = S_EMIT;
                end
            end
            S_INS_HEAD: begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = new_reg;
                count_next = count_reg + CNT_W'(1);
                pend_next  = make_result(ST_OK, '0, 1'b0, count_next, 1'b1);
                state_next = S_EMIT;
            end
            S_REM: begin
                head_next  = wrap_add(head_reg, IDX_W'(1));
                count_next = count_reg - CNT_W'(1);
                pend_next  = make_result(ST_OK, rd_data, 1'b1, count_next, 1'b1);
                state_next = S_EMIT;
            end
            S_DUMP: begin
                if (res_take) begin
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = wrap_add(head_reg, j_inc);
                        j_next  = j_inc;
                    end
                end
            end
            S_EMIT: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg    <= j_next;
        new_reg  <= new_next;
        pend_reg <= pend_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ins_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INS |-> CNT_W'(j_reg) < count_reg)
        else $error("insert scan index outside stored entries");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && rd_en |-> wr_addr != rd_addr)
        else $error("read and write to the same entry in one cycle");

    a_dump_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |=> $stable(count_reg) && $stable(head_reg))
        else $error("store changed during dump");
`endif

endmodule

FILE: tb/stable_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking bench for the stable priority queue. A short directed table
// covers empty, out-of-range and FIFO-among-equals cases, a fill past
// capacity covers the full case, then random insert/remove/dump traffic
// alternates between draining and filling phases. Each result is compared in
// order against the table's expected row or a behavioral copy of the store.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        result_t           res;
    } stim_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0]   s_opcode = '0;
    logic [CODE_W-1:0] s_item_code = '0;
    logic [PRIO_W-1:0] s_item_priority = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ST_W-1:0]   m_status;
    logic [CODE_W-1:0] m_out_code;
    logic [PRIO_W-1:0] m_out_priority;
    logic [OCC_W-1:0]  m_occupancy;
    logic              m_last;

    entry_t    sorted_store[$];
    result_t   op_results[$];
    result_t   pending_results[$];
    stim_row_t dir_rows[$];

    bit idle_en = 1'b0;
    bit hold_pending = 1'b0;
    int rx_wait = 0;
    int quiet_cycles = 0;
    int err_count = 0;

    stable_priority_queue uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_item_code     (s_item_code),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_code      (m_out_code),
        .m_out_priority  (m_out_priority),
        .m_occupancy     (m_occupancy),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic result_t queue_result(input logic [ST_W-1:0] status,
                                             input logic [CODE_W-1:0] code,
                                             input logic [PRIO_W-1:0] prio,
                                             input logic last);
        result_t r;
        r.status = status;
        r.code   = code;
        r.prio   = prio;
        r.occ    = OCC_W'(sorted_store.size());
        r.last   = last;
        return r;
    endfunction

    // Applies one transaction to the sorted store and collects its results.
    function automatic void apply_queue_op(input logic [OP_W-1:0] op,
                                           input logic [CODE_W-1:0] code,
                                           input logic [PRIO_W-1:0] prio);
        int pos;
        entry_t ent;
        op_results.delete();
        case (op)
            OP_INSERT: begin
                if (sorted_store.size() >= DEPTH) begin
                    op_results.push_back(queue_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    pos = 0;
                    while (pos < sorted_store.size()) begin
                        ent = sorted_store[pos];
                        if (ent[PRIO_W-1:0] > prio) break;
                        pos++;
                    end
                    sorted_store.insert(pos, {code, prio});
                    op_results.push_back(queue_result(ST_OK, '0, '0, 1'b1));
                end
            end
            OP_REMOVE: begin
                if (sorted_store.size() == 0) begin
                    op_results.push_back(queue_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    ent = sorted_store.pop_front();
                    op_results.push_back(queue_result(ST_OK, ent[ENT_W-1:PRIO_W],
                                                      ent[PRIO_W-1:0], 1'b1));
                end
            end
            OP_DUMP: begin
                if (sorted_store.size() == 0) begin
                    op_results.push_back(queue_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    foreach (sorted_store[i]) begin
                        ent = sorted_store[i];
                        op_results.push_back(queue_result(ST_OK, ent[ENT_W-1:PRIO_W],
                                                          ent[PRIO_W-1:0],
                                                          i == sorted_store.size() - 1));
                    end
                end
            end
            default: begin
                op_results.push_back(queue_result(ST_OK, '0, '0, 1'b1));
            end
        endcase
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [PRIO_W-1:0] prio, input logic typed,
                           input logic [ST_W-1:0] st, input logic [CODE_W-1:0] out_code,
                           input logic [PRIO_W-1:0] out_prio, input int occ);
        stim_row_t row;
        row.op   = op;
        row.code = code;
        row.prio = prio;
        row.typed = typed;
        row.res  = '{status: st, code: out_code, prio: out_prio,
                     occ: OCC_W'(occ), last: 1'b1};
        dir_rows.push_back(row);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input result_t typed_res);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_item_code     <= code;
        s_item_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        apply_queue_op(op, code, prio);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            foreach (op_results[i]) pending_results.push_back(op_results[i]);
        end
    endtask

    task automatic send_random(input int ins_pct);
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < 88) op = OP_REMOVE;
        else if (r < 97) op = OP_DUMP;
        else op = OP_UNUSED;
        if ($urandom_range(0, 9) == 0) code = CODE_W'($urandom_range(0, 1023));
        else code = CODE_W'($urandom_range(0, 999));
        r = $urandom_range(0, 9);
        if (r < 5) prio = PRIO_W'($urandom_range(1, 20));
        else if (r < 8) prio = PRIO_W'($urandom_range(1, 4));
        else prio = PRIO_W'($urandom_range(0, 31));
        send_item(op, code, prio, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_pending) begin
            m_ready      <= 1'b0;
            hold_pending <= 1'b0;
            rx_wait      <= HOLD_CYCLES - 1;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_wait <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{status: m_status, code: m_out_code, prio: m_out_priority,
                    occ: m_occupancy, last: m_last};
            if (pending_results.size() == 0) begin
                $display({"%0t: unexpected transaction status=%0d code=%0d prio=%0d",
                          " occ=%0d last=%0d"},
                         $time, got.status, got.code, got.prio, got.occ, got.last);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display({"%0t: mismatch expected status=%0d code=%0d prio=%0d",
                              " occ=%0d last=%0d"},
                             $time, want.status, want.code, want.prio, want.occ,
                             want.last);
                    $display({"%0t:          actual   status=%0d code=%0d prio=%0d",
                              " occ=%0d last=%0d"},
                             $time, got.status, got.code, got.prio, got.occ, got.last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int n_fill;
        add_row(OP_REMOVE, 10'd0,    5'd0,  1'b1, ST_EMPTY, 10'd0,   5'd0, 0);
        add_row(OP_DUMP,   10'd0,    5'd0,  1'b1, ST_EMPTY, 10'd0,   5'd0, 0);
        add_row(OP_UNUSED, 10'd1023, 5'd31, 1'b1, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_INSERT, 10'd999,  5'd20, 1'b1, ST_OK,    10'd0,   5'd0, 1);
        add_row(OP_INSERT, 10'd0,    5'd1,  1'b1, ST_OK,    10'd0,   5'd0, 2);
        add_row(OP_INSERT, 10'd1023, 5'd31, 1'b1, ST_OK,    10'd0,   5'd0, 3);
        add_row(OP_INSERT, 10'd512,  5'd0,  1'b1, ST_OK,    10'd0,   5'd0, 4);
        add_row(OP_INSERT, 10'd341,  5'd20, 1'b1, ST_OK,    10'd0,   5'd0, 5);
        add_row(OP_INSERT, 10'd682,  5'd1,  1'b1, ST_OK,    10'd0,   5'd0, 6);
        add_row(OP_INSERT, 10'd7,    5'd10, 1'b1, ST_OK,    10'd0,   5'd0, 7);
        add_row(OP_DUMP,   10'd0,    5'd0,  1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_REMOVE, 10'd0,    5'd0,  1'b1, ST_OK,    10'd512, 5'd0, 6);
        add_row(OP_REMOVE, 10'd77,   5'd9,  1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_REMOVE, 10'd0,    5'd0,  1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_UNUSED, 10'd5,    5'd3,  1'b1, ST_OK,    10'd0,   5'd0, 4);
        add_row(OP_INSERT, 10'd100,  5'd20, 1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_INSERT, 10'd101,  5'd31, 1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_DUMP,   10'd0,    5'd0,  1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_REMOVE, 10'd0,    5'd0,  1'b0, ST_OK,    10'd0,   5'd0, 0);
        add_row(OP_REMOVE, 10'd0,    5'd0,  1'b0, ST_OK,    10'd0,   5'd0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        idle_en <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].op, dir_rows[i].code, dir_rows[i].prio,
                      dir_rows[i].typed, dir_rows[i].res);
        end
        wait_drained();

        // fill past capacity while the result side is held off
        hold_pending <= 1'b1;
        n_fill = DEPTH + 3 - sorted_store.size();
        repeat (n_fill) begin
            send_item(OP_INSERT, CODE_W'($urandom_range(0, 1023)),
                      PRIO_W'($urandom_range(0, 31)), 1'b0, '0);
        end
        send_item(OP_DUMP, '0, '0, 1'b0, '0);
        wait_drained();

        for (int round = 0; round < 4; round++) begin
            repeat (30) send_random((round % 2 == 0) ? 25 : 70);
            if (round == 1) wait_drained();
        end

        idle_en <= 1'b0;
        repeat (30) send_random(50);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
